// ===== sv/sia_pkg.sv =====
package sia_pkg;

    // fixed field widths
    localparam int MODE_W  = 3;
    localparam int INDEX_W = 8;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 9;

    // position width, wide enough for the largest supported depth (65536)
    localparam int POS_W = 17;

    localparam int DEPTH_DEFAULT  = 256;
    localparam int LENGTH_DEFAULT = 256;

    // APB register map
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_LENGTH = 1'b0;

    // empty slot marker
    localparam logic [DATA_W-1:0] EMPTY_WORD = {1'b1, {(DATA_W-1){1'b0}}};

    // operation codes
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_REPLACE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_INSERT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_ERASE   = 3'd5;

    // status codes
    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // cell commands
    localparam int CMD_W = 3;
    localparam logic [CMD_W-1:0] CMD_NONE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ERASE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SHR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SHL   = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0]         mode;
        logic [INDEX_W-1:0]        slot_index;
        logic signed [DATA_W-1:0]  key_value;
    } sia_req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  old_value;
        logic [STAT_W-1:0]         status;
    } sia_rsp_t;

    // broadcast to every cell of the row
    typedef struct packed {
        logic [CMD_W-1:0]   op;
        logic [POS_W-1:0]   pos;
        logic [POS_W-1:0]   last;
        logic [DATA_W-1:0]  key;
    } sia_cmd_t;

endpackage

// ===== sv/shift_insert_array_engine.sv =====
// channel  | handshake                 | word
// ---------+---------------------------+-------------------------------------
// in       | in_valid / in_ready       | in_data  : mode, slot_index, key_value
// out      | out_valid / out_ready     | out_data : old_value, status
// cfg      | APB psel/penable/pwrite   | pwdata / prdata : length
//
// Each word is captured into a register, then executed; no new word is taken
// until it has executed. The execute step is set by the select of the addressed
// and the last slot out of the cell row and the update of every cell at once.
// Reset clears every slot to the empty value in the same cycle; no sweep.
// A full output register stalls execution; the captured word waits in place.
module shift_insert_array_engine #(
    parameter int DEPTH = sia_pkg::DEPTH_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  sia_pkg::sia_req_t           in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output sia_pkg::sia_rsp_t           out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sia_pkg::PADDR_W-1:0] paddr,
    input  logic [sia_pkg::PDATA_W-1:0] pwdata,
    output logic [sia_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import sia_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);

    logic [LEN_W-1:0]            length_reg;
    logic                        busy_reg;
    sia_req_t                    op_reg;
    logic                        out_valid_reg;
    sia_rsp_t                    out_reg;

    logic [DEPTH-1:0][DATA_W-1:0] slot_w;
    logic [POS_W-1:0]            len_pos;
    logic [POS_W-1:0]            used_len;
    logic [POS_W-1:0]            idx_pos;
    logic [POS_W-1:0]            last_pos;
    logic                        in_range;
    logic [DATA_W-1:0]           idx_word;
    logic [DATA_W-1:0]           last_word;
    logic                        exec;
    logic [CMD_W-1:0]            cmd_op;
    sia_cmd_t                    cmd;
    sia_rsp_t                    rsp;

    // configuration port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LENGTH) ? PDATA_W'(length_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            length_reg <= LEN_W'(LENGTH_DEFAULT);
        else if (psel && penable && pwrite && (paddr[2] == REG_LENGTH))
            length_reg <= pwdata[LEN_W-1:0];
    end

    // clamp the length to the row and locate the addressed and last slot
    assign len_pos  = POS_W'(length_reg);
    assign used_len = (len_pos > DEPTH_POS) ? DEPTH_POS : len_pos;
    assign idx_pos  = POS_W'(op_reg.slot_index);
    assign last_pos = used_len - POS_W'(1);
    assign in_range = (idx_pos < used_len);

    assign idx_word  = slot_w[idx_pos[AW-1:0]];
    assign last_word = slot_w[last_pos[AW-1:0]];

    assign exec = busy_reg && (!out_valid_reg || out_ready);

    // decode the captured word into a cell command and a result
    always_comb
    begin
        cmd_op        = CMD_NONE;
        rsp.old_value = '0;
        rsp.status    = STATUS_OK;
        if (!in_range)
        begin
            rsp.status = (op_reg.mode > MODE_ERASE) ? STATUS_OK : STATUS_RANGE;
        end
        else
        begin
            unique case (op_reg.mode)
                MODE_READ:
                begin
                    rsp.old_value = idx_word;
                end
                MODE_WRITE:
                begin
                    cmd_op = CMD_WRITE;
                end
                MODE_REPLACE:
                begin
                    rsp.old_value = idx_word;
                    cmd_op        = CMD_WRITE;
                end
                MODE_INSERT:
                begin
                    if (idx_word == EMPTY_WORD)
                        cmd_op = CMD_WRITE;
                    else if (last_word == EMPTY_WORD)
                        cmd_op = CMD_SHR;
                    else
                        rsp.status = STATUS_FULL;
                end
                MODE_POP:
                begin
                    rsp.old_value = idx_word;
                    cmd_op        = CMD_SHL;
                end
                MODE_ERASE:
                begin
                    cmd_op = CMD_ERASE;
                end
                default:
                begin
                    cmd_op = CMD_NONE;
                end
            endcase
        end
    end

    assign cmd.op   = exec ? cmd_op : CMD_NONE;
    assign cmd.pos  = idx_pos;
    assign cmd.last = last_pos;
    assign cmd.key  = op_reg.key_value;

    // row of slot cells, each linked to both neighbors
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_w;
        logic [DATA_W-1:0] right_w;

        if (g == 0)
        begin : g_first
            assign left_w = EMPTY_WORD;
        end
        else
        begin : g_mid_l
            assign left_w = slot_w[g-1];
        end

        if (g == DEPTH - 1)
        begin : g_last
            assign right_w = EMPTY_WORD;
        end
        else
        begin : g_mid_r
            assign right_w = slot_w[g+1];
        end

        sia_cell #(
            .CELL_ID(g)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd),
            .left_value (left_w),
            .right_value(right_w),
            .value      (slot_w[g])
        );
    end

    // capture one word, hold it until its result can be registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (in_valid && in_ready)
            busy_reg <= 1'b1;
        else if (exec)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            op_reg <= in_data;
    end

    assign in_ready = !busy_reg;

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (exec)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (exec)
            out_reg <= rsp;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ===== sv/sia_cell.sv =====
module sia_cell #(
    parameter int CELL_ID = 0
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  sia_pkg::sia_cmd_t         cmd,
    input  logic [sia_pkg::DATA_W-1:0] left_value,
    input  logic [sia_pkg::DATA_W-1:0] right_value,
    output logic [sia_pkg::DATA_W-1:0] value
);
    import sia_pkg::*;

    localparam logic [POS_W-1:0] MY_POS = POS_W'(CELL_ID);

    logic [DATA_W-1:0] value_reg;
    logic [DATA_W-1:0] value_next;
    logic              at_pos;
    logic              above_pos;
    logic              at_last;
    logic              below_last;

    assign at_pos     = (MY_POS == cmd.pos);
    assign above_pos  = (MY_POS > cmd.pos);
    assign at_last    = (MY_POS == cmd.last);
    assign below_last = (MY_POS < cmd.last);

    // pick own next word from the broadcast command and the neighbors
    always_comb
    begin
        value_next = value_reg;
        case (cmd.op)
            CMD_WRITE:
            begin
                if (at_pos)
                    value_next = cmd.key;
            end
            CMD_ERASE:
            begin
                if (at_pos)
                    value_next = EMPTY_WORD;
            end
            CMD_SHR:
            begin
                if (at_pos)
                    value_next = cmd.key;
                else if (above_pos && (below_last || at_last))
                    value_next = left_value;
            end
            CMD_SHL:
            begin
                if (at_last)
                    value_next = EMPTY_WORD;
                else if ((above_pos || at_pos) && below_last)
                    value_next = right_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            value_reg <= EMPTY_WORD;
        else
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule
